// ===== rtl/core/brm_pkg.sv =====
package brm_pkg;

  localparam int TableEntries = 10;
  localparam int RomIdxW      = 4;
  localparam int Len43        = 8;
  localparam int Len169       = 10;

  localparam logic [2:0] RegDynamicEnable = 3'd0;
  localparam logic [2:0] RegAspect43      = 3'd1;
  localparam logic [2:0] RegInitialEnable = 3'd2;
  localparam logic [2:0] RegInitialWidth  = 3'd3;
  localparam logic [2:0] RegInitialHeight = 3'd4;

  localparam logic [10:0] InitWidthReset  = 11'd640;
  localparam logic [10:0] InitHeightReset = 11'd480;

  typedef enum logic [1:0] {
    SEL_INIT,
    SEL_KEEP,
    SEL_EARLY,
    SEL_END
  } sel_e;

  typedef struct packed {
    logic        dynamic_enable;
    logic        aspect_four_three;
    logic        initial_enable;
    logic [10:0] initial_width;
    logic [10:0] initial_height;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic step;
    logic emit;
    sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic better;
    logic at_end;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [10:0] w;
    logic [10:0] h;
    logic [12:0] avg;
  } entry_t;

  function automatic entry_t rom_entry(input logic four_three, input logic [RomIdxW-1:0] idx);
    entry_t e;
    e = '0;
    if (four_three) begin
      unique case (idx)
        4'd0: e = '{w: 11'd320,  h: 11'd240,  avg: 13'd295};
        4'd1: e = '{w: 11'd400,  h: 11'd300,  avg: 13'd462};
        4'd2: e = '{w: 11'd512,  h: 11'd384,  avg: 13'd756};
        4'd3: e = '{w: 11'd640,  h: 11'd480,  avg: 13'd1182};
        4'd4: e = '{w: 11'd1024, h: 11'd768,  avg: 13'd3027};
        4'd5: e = '{w: 11'd1152, h: 11'd864,  avg: 13'd3831};
        4'd6: e = '{w: 11'd1296, h: 11'd972,  avg: 13'd4849};
        4'd7: e = '{w: 11'd1640, h: 11'd1232, avg: 13'd7778};
        default: e = '0;
      endcase
    end else begin
      unique case (idx)
        4'd0: e = '{w: 11'd384,  h: 11'd216,  avg: 13'd319};
        4'd1: e = '{w: 11'd512,  h: 11'd288,  avg: 13'd567};
        4'd2: e = '{w: 11'd640,  h: 11'd360,  avg: 13'd886};
        4'd3: e = '{w: 11'd768,  h: 11'd432,  avg: 13'd1277};
        4'd4: e = '{w: 11'd896,  h: 11'd504,  avg: 13'd1738};
        4'd5: e = '{w: 11'd1024, h: 11'd576,  avg: 13'd2270};
        4'd6: e = '{w: 11'd1152, h: 11'd648,  avg: 13'd2873};
        4'd7: e = '{w: 11'd1280, h: 11'd720,  avg: 13'd3548};
        4'd8: e = '{w: 11'd1408, h: 11'd864,  avg: 13'd4683};
        4'd9: e = '{w: 11'd1920, h: 11'd1080, avg: 13'd7983};
        default: e = '0;
      endcase
    end
    return e;
  endfunction

endpackage

// ===== rtl/core/brm_ctrl.sv =====
module brm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             operation_i,
  input  brm_pkg::cfg_t    cfg_i,
  input  brm_pkg::status_t status_i,
  output logic             in_ready_o,
  output brm_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_e;

  state_e        state_q;
  brm_pkg::sel_e sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      sel_q   <= brm_pkg::SEL_KEEP;
    end else begin
      unique case (state_q)
        IDLE: begin
          if (in_valid_i) begin
            if (operation_i && cfg_i.initial_enable) begin
              sel_q   <= brm_pkg::SEL_INIT;
              state_q <= FINISH;
            end else if (!cfg_i.dynamic_enable) begin
              sel_q   <= brm_pkg::SEL_KEEP;
              state_q <= FINISH;
            end else begin
              state_q <= SCAN;
            end
          end
        end
        SCAN: begin
          if (!status_i.better) begin
            sel_q   <= brm_pkg::SEL_EARLY;
            state_q <= FINISH;
          end else if (status_i.at_end) begin
            sel_q   <= brm_pkg::SEL_END;
            state_q <= FINISH;
          end
        end
        FINISH: begin
          if (status_i.out_free) begin
            state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign in_ready_o   = (state_q == IDLE);
  assign cmd_o.start  = (state_q == IDLE) && in_valid_i;
  assign cmd_o.step   = (state_q == SCAN) && status_i.better;
  assign cmd_o.emit   = (state_q == FINISH) && status_i.out_free;
  assign cmd_o.sel    = sel_q;

endmodule

// ===== rtl/core/brm_datapath.sv =====
module brm_datapath #(
  parameter int TABLE_ENTRIES = brm_pkg::TableEntries
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  brm_pkg::cfg_t    cfg_i,
  input  brm_pkg::cmd_t    cmd_i,
  input  logic [21:0]      target_kbps_i,
  input  logic             out_ready_i,
  output brm_pkg::status_t status_o,
  output logic             out_valid_o,
  output logic [10:0]      width_px_o,
  output logic [10:0]      height_px_o,
  output logic             changed_o
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int N43  = (brm_pkg::Len43 < TABLE_ENTRIES) ? brm_pkg::Len43 : TABLE_ENTRIES;
  localparam int N169 = (brm_pkg::Len169 < TABLE_ENTRIES) ? brm_pkg::Len169 : TABLE_ENTRIES;
  localparam logic [IdxW-1:0] Last43  = IdxW'(N43 - 1);
  localparam logic [IdxW-1:0] Last169 = IdxW'(N169 - 1);

  logic [21:0]     target_q;
  logic [IdxW-1:0] idx_q;
  logic            have_best_q;
  logic [21:0]     last_q;
  logic [10:0]     best_w_q, best_h_q;
  logic [10:0]     cur_w_q, cur_h_q;
  logic            out_valid_q;
  logic [10:0]     out_w_q, out_h_q;
  logic            out_chg_q;

  brm_pkg::entry_t entry;
  logic [21:0]     avg;
  logic [21:0]     gap;
  logic [10:0]     res_w, res_h;
  logic            res_chg;

  assign entry = brm_pkg::rom_entry(cfg_i.aspect_four_three, brm_pkg::RomIdxW'(idx_q));
  assign avg   = 22'(entry.avg);
  assign gap   = (avg > target_q) ? (avg - target_q) : (target_q - avg);

  assign status_o.better   = !have_best_q || (gap < last_q);
  assign status_o.at_end   = (idx_q == (cfg_i.aspect_four_three ? Last43 : Last169));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (cmd_i.sel)
      brm_pkg::SEL_INIT: begin
        res_w   = cfg_i.initial_width;
        res_h   = cfg_i.initial_height;
        res_chg = 1'b1;
      end
      brm_pkg::SEL_KEEP: begin
        res_w   = cur_w_q;
        res_h   = cur_h_q;
        res_chg = 1'b0;
      end
      brm_pkg::SEL_EARLY: begin
        res_w   = best_w_q;
        res_h   = best_h_q;
        res_chg = (best_w_q != cur_w_q) || (best_h_q != cur_h_q);
      end
      brm_pkg::SEL_END: begin
        res_w   = best_w_q;
        res_h   = best_h_q;
        res_chg = 1'b1;
      end
      default: begin
        res_w   = cur_w_q;
        res_h   = cur_h_q;
        res_chg = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      target_q <= target_kbps_i;
      idx_q    <= '0;
    end else if (cmd_i.step) begin
      idx_q    <= idx_q + 1'b1;
      last_q   <= gap;
      best_w_q <= entry.w;
      best_h_q <= entry.h;
    end
    if (cmd_i.emit) begin
      out_w_q   <= res_w;
      out_h_q   <= res_h;
      out_chg_q <= res_chg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
      cur_w_q     <= '0;
      cur_h_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        have_best_q <= 1'b0;
      end else if (cmd_i.step) begin
        have_best_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        cur_w_q     <= res_w;
        cur_h_q     <= res_h;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign width_px_o  = out_w_q;
  assign height_px_o = out_h_q;
  assign changed_o   = out_chg_q;

endmodule

// ===== rtl/core/bitrate_resolution_matcher_core.sv =====
// Channel   Dir  Bus                      Word
// s_axis    in   tdata 24, tuser 1        target_kbps; operation
// m_axis    out  tdata 24                 width_px, height_px, changed
// apb       in   32-bit data, 5-bit addr  configuration registers
//
// A bitrate item goes from acceptance straight to the result register when dynamic mode
// is off or the initial resolution is forced; otherwise the table entries are first
// scanned one per cycle by the distance compare, up to all 10 of the full 16:9 table.
// A finished word waits in the output register while the next item is taken; the next
// result then stalls until that word has been accepted.
// Reset clears the stored resolution to zero and the registers to their defaults.
module bitrate_resolution_matcher_core #(
  parameter int TABLE_ENTRIES = brm_pkg::TableEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // target_kbps[21:0], zero pad
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // width_px[10:0], height_px[21:11], changed[22], pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  brm_pkg::cfg_t    cfg_q;
  brm_pkg::cmd_t    cmd;
  brm_pkg::status_t status;
  logic [10:0]      width_px, height_px;
  logic             changed;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dynamic_enable    <= 1'b1;
      cfg_q.aspect_four_three <= 1'b0;
      cfg_q.initial_enable    <= 1'b0;
      cfg_q.initial_width     <= brm_pkg::InitWidthReset;
      cfg_q.initial_height    <= brm_pkg::InitHeightReset;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        brm_pkg::RegDynamicEnable: cfg_q.dynamic_enable    <= pwdata[0];
        brm_pkg::RegAspect43:      cfg_q.aspect_four_three <= pwdata[0];
        brm_pkg::RegInitialEnable: cfg_q.initial_enable    <= pwdata[0];
        brm_pkg::RegInitialWidth:  cfg_q.initial_width     <= pwdata[10:0];
        brm_pkg::RegInitialHeight: cfg_q.initial_height    <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      brm_pkg::RegDynamicEnable: prdata = {31'd0, cfg_q.dynamic_enable};
      brm_pkg::RegAspect43:      prdata = {31'd0, cfg_q.aspect_four_three};
      brm_pkg::RegInitialEnable: prdata = {31'd0, cfg_q.initial_enable};
      brm_pkg::RegInitialWidth:  prdata = {21'd0, cfg_q.initial_width};
      brm_pkg::RegInitialHeight: prdata = {21'd0, cfg_q.initial_height};
      default:                   prdata = '0;
    endcase
  end

  brm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .operation_i (s_axis_tuser),
    .cfg_i       (cfg_q),
    .status_i    (status),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  brm_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .target_kbps_i (s_axis_tdata[21:0]),
    .out_ready_i   (m_axis_tready),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid),
    .width_px_o    (width_px),
    .height_px_o   (height_px),
    .changed_o     (changed)
  );

  assign m_axis_tdata = {1'b0, changed, height_px, width_px};

endmodule

// ===== rtl/core/brm_checker.sv =====
module brm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  logic       in_acc, out_acc;
  logic [1:0] pending_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input taken again before the current word was resolved");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pending_q != 2'd0)
    else $error("result word without an outstanding input word");

  a_bounded_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pending_q < 2'd2)
    else $error("more than one word held back inside the block");

endmodule

bind bitrate_resolution_matcher_core brm_checker u_brm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
